// ===== rtl/core/ffa_pkg.sv =====
// Package for the first-fit free-list allocator: sizes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;
   localparam int AddrW = 10;
   localparam int PoolUnits = 1024;
   typedef logic [AddrW-1:0] addr_type;
   typedef enum logic [4:0] {
      ST_IDLE, ST_A_RD, ST_A_EV, ST_A_RDN, ST_A_EX, ST_A_PRD, ST_A_PEV,
      ST_F_RD, ST_F_EV, ST_F_BRD, ST_F_NRD, ST_F_M1, ST_F_PRD, ST_F_M2,
      ST_DONE
   } state_type;
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/ffa_ram.sv =====
// Single-port-write, single-read header store (link or size) for the allocator.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram (
   input  wire logic clock,
   input  wire logic we,
   input  wire ffa_pkg::addr_type waddr,
   input  wire ffa_pkg::addr_type wdata,
   input  wire ffa_pkg::addr_type raddr,
   output ffa_pkg::addr_type rdata
);
   ffa_pkg::addr_type mem [ffa_pkg::PoolUnits];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// First-fit free-list allocator with coalescing, top level and sequencer.
// Depends on ffa_pkg and ffa_ram.
//
// Usage: raise start with req_type (0 allocate, 1 free), req_request_units and
// req_block_addr while busy is low; the item is taken at that edge and busy
// rises. The sequencer walks the circular free list one header per memory
// read, each visit passing through a read state and an evaluate state. When
// done, rsp_valid pulses for one cycle with rsp_status and rsp_payload_addr,
// and busy drops the next cycle. Items are handled one at a time.
// Reset (synchronous, active high) empties nothing: the pool is one free
// block at unit 0 of size 1023 and the header of unit 0 is written in the
// cycle after reset while busy stays high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_list_allocator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_type,
   input  wire logic [9:0] req_request_units,
   input  wire logic [9:0] req_block_addr,
   output logic            rsp_valid,
   output logic            rsp_status,
   output logic [9:0]      rsp_payload_addr
);
   typedef ffa_pkg::addr_type ptr_type;
   ffa_pkg::state_type state_ff, state_in;
   ptr_type cur_ff, cur_in, prv_ff, prv_in, n_ff, n_in, bp_ff, bp_in;
   ptr_type nx_ff, nx_in, bsz_ff, bsz_in, t_ff, t_in;
   ptr_type head_ff, head_in;
   logic empty_ff, empty_in, hasp_ff, hasp_in, init_ff, init_in;
   logic [10:0] k_ff, k_in;
   logic st_ff, st_in;
   ptr_type addr_ff, addr_in;
   logic lwe, swe;
   ptr_type lwa, lwd, swa, swd, lra, sra, lrd, srd;

   ffa_ram u_link (.clock, .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
   ffa_ram u_size (.clock, .we(swe), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::ST_IDLE;
         head_ff <= '0;
         empty_ff <= 1'b0;
         init_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         empty_ff <= empty_in;
         init_ff <= init_in;
      end
      cur_ff <= cur_in; prv_ff <= prv_in; n_ff <= n_in; bp_ff <= bp_in;
      nx_ff <= nx_in; bsz_ff <= bsz_in; t_ff <= t_in;
      hasp_ff <= hasp_in; k_ff <= k_in; st_ff <= st_in; addr_ff <= addr_in;
   end

   // next state, registers and memory ports
   always_comb begin
      state_in = state_ff; cur_in = cur_ff; prv_in = prv_ff; n_in = n_ff;
      bp_in = bp_ff; nx_in = nx_ff; bsz_in = bsz_ff; t_in = t_ff;
      head_in = head_ff; empty_in = empty_ff; hasp_in = hasp_ff; init_in = 1'b0;
      k_in = k_ff; st_in = st_ff; addr_in = addr_ff;
      lwe = 1'b0; swe = 1'b0; lwa = cur_ff; lwd = '0; swa = cur_ff; swd = '0;
      lra = cur_ff; sra = cur_ff;
      case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (init_ff) begin
               lwe = 1'b1; lwa = '0; lwd = '0;
               swe = 1'b1; swa = '0; swd = ptr_type'(ffa_pkg::PoolUnits - 1);
            end else if (start) begin
               st_in = 1'b0; addr_in = '0; k_in = '0; hasp_in = 1'b0;
               cur_in = head_ff;
               n_in = (req_request_units == '0) ? ptr_type'(1) : req_request_units;
               bp_in = req_block_addr - ptr_type'(1);
               if (req_type == ffa_pkg::REQ_ALLOC) begin
                  if (empty_ff) begin
                     st_in = 1'b1; state_in = ffa_pkg::ST_DONE;
                  end else begin
                     state_in = ffa_pkg::ST_A_RD;
                  end
               end else if (empty_ff) begin
                  lwe = 1'b1; lwa = req_block_addr - ptr_type'(1); lwd = lwa;
                  head_in = lwa; empty_in = 1'b0; state_in = ffa_pkg::ST_DONE;
               end else begin
                  state_in = ffa_pkg::ST_F_RD;
               end
            end
         end
         // allocate walk: issue read of cur
         ffa_pkg::ST_A_RD: begin
            lra = cur_ff; sra = cur_ff; state_in = ffa_pkg::ST_A_EV;
         end
         ffa_pkg::ST_A_EV: begin
            nx_in = lrd;
            if (srd >= n_ff) begin
               if (srd - n_ff <= ptr_type'(1)) begin
                  addr_in = cur_ff + ptr_type'(1);
                  if (lrd == cur_ff) begin
                     empty_in = 1'b1; state_in = ffa_pkg::ST_DONE;
                  end else if (hasp_ff) begin
                     lwe = 1'b1; lwa = prv_ff; lwd = lrd; state_in = ffa_pkg::ST_DONE;
                  end else begin
                     t_in = head_ff; k_in = '0; state_in = ffa_pkg::ST_A_PRD;
                  end
               end else begin
                  swe = 1'b1; swa = cur_ff; swd = srd - n_ff - ptr_type'(1);
                  t_in = cur_ff + srd - n_ff;
                  state_in = ffa_pkg::ST_A_EX;
               end
            end else begin
               prv_in = cur_ff; hasp_in = 1'b1; cur_in = lrd; k_in = k_ff + 11'd1;
               if (lrd == head_ff || k_ff + 11'd1 >= 11'(ffa_pkg::PoolUnits)) begin
                  st_in = 1'b1; state_in = ffa_pkg::ST_DONE;
               end else begin
                  state_in = ffa_pkg::ST_A_RD;
               end
            end
         end
         ffa_pkg::ST_A_EX: begin
            swe = 1'b1; swa = t_ff; swd = n_ff; addr_in = t_ff + ptr_type'(1);
            state_in = ffa_pkg::ST_DONE;
         end
         // find predecessor of head block cur
         ffa_pkg::ST_A_PRD: begin
            lra = t_ff; state_in = ffa_pkg::ST_A_PEV;
         end
         ffa_pkg::ST_A_PEV: begin
            if (lrd == cur_ff) begin
               lwe = 1'b1; lwa = t_ff; lwd = nx_ff;
               head_in = nx_ff; state_in = ffa_pkg::ST_DONE;
            end else if (k_ff >= 11'(ffa_pkg::PoolUnits)) begin
               head_in = nx_ff; state_in = ffa_pkg::ST_DONE;
            end else begin
               t_in = lrd; k_in = k_ff + 11'd1; state_in = ffa_pkg::ST_A_PRD;
            end
         end
         // free: walk for insertion point p (in cur)
         ffa_pkg::ST_F_RD: begin
            lra = cur_ff; sra = cur_ff; state_in = ffa_pkg::ST_F_EV;
         end
         ffa_pkg::ST_F_EV: begin
            nx_in = lrd;
            if ((bp_ff > cur_ff && bp_ff < lrd) || k_ff >= 11'(ffa_pkg::PoolUnits)
                || (cur_ff >= lrd && (bp_ff > cur_ff || bp_ff < lrd))) begin
               state_in = ffa_pkg::ST_F_BRD;
            end else begin
               cur_in = lrd; k_in = k_ff + 11'd1; state_in = ffa_pkg::ST_F_RD;
            end
         end
         ffa_pkg::ST_F_BRD: begin
            sra = bp_ff; lra = nx_ff; state_in = ffa_pkg::ST_F_NRD;
         end
         ffa_pkg::ST_F_NRD: begin
            bsz_in = srd; t_in = lrd; sra = nx_ff; state_in = ffa_pkg::ST_F_M1;
         end
         // merge with successor; srd is sz(nxt), t is lnk(nxt)
         ffa_pkg::ST_F_M1: begin
            if (bp_ff + ptr_type'(1) + bsz_ff == nx_ff) begin
               swe = 1'b1; swa = bp_ff;
               swd = (bp_ff == nx_ff) ? bsz_ff : bsz_ff + ptr_type'(1) + srd;
               bsz_in = swd;
               lwe = 1'b1; lwa = bp_ff;
               if (nx_ff == cur_ff) begin
                  lwd = bp_ff; head_in = bp_ff; state_in = ffa_pkg::ST_DONE;
               end else begin
                  lwd = t_ff;
                  nx_in = lwd; state_in = ffa_pkg::ST_F_PRD;
               end
            end else begin
               lwe = 1'b1; lwa = bp_ff; lwd = nx_ff; state_in = ffa_pkg::ST_F_PRD;
            end
         end
         // merge with predecessor; sz(p) may have changed if p == bp
         ffa_pkg::ST_F_PRD: begin
            sra = cur_ff; lra = bp_ff; state_in = ffa_pkg::ST_F_M2;
         end
         ffa_pkg::ST_F_M2: begin
            if (cur_ff + ptr_type'(1) + srd == bp_ff) begin
               swe = 1'b1; swa = cur_ff; swd = srd + ptr_type'(1) + bsz_ff;
               lwe = 1'b1; lwa = cur_ff; lwd = lrd; head_in = cur_ff;
            end else begin
               lwe = 1'b1; lwa = cur_ff; lwd = bp_ff; head_in = bp_ff;
            end
            state_in = ffa_pkg::ST_DONE;
         end
         ffa_pkg::ST_DONE: state_in = ffa_pkg::ST_IDLE;
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = (state_ff != ffa_pkg::ST_IDLE) || init_ff;
      rsp_valid = (state_ff == ffa_pkg::ST_DONE);
      rsp_status = st_ff;
      rsp_payload_addr = addr_ff;
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result while idle");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> rsp_payload_addr == '0)
      else $error("failed allocation returns an address");
endmodule
`default_nettype wire

// ===== dv/tb_first_fit_free_list_allocator.sv =====
// Testbench for first_fit_free_list_allocator: directed table, then random allocate/free traffic.
// Depends on ffa_pkg and the allocator RTL. Expected: typed row values, else the free-list model.
`timescale 1ns / 1ps
module tb_first_fit_free_list_allocator;

   localparam int QuietLimit = 40000;
   localparam int RandomItems = 750;

   typedef struct packed {
      logic              status;
      ffa_pkg::addr_type payload;
   } outcome_type;

   typedef struct {
      logic              kind;
      ffa_pkg::addr_type units;
      ffa_pkg::addr_type addr;
      bit                typed;
      logic              status;
      ffa_pkg::addr_type payload;
   } row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              req_type = ffa_pkg::REQ_ALLOC;
   ffa_pkg::addr_type req_request_units = '0;
   ffa_pkg::addr_type req_block_addr = '0;
   logic              busy, rsp_valid, rsp_status;
   ffa_pkg::addr_type rsp_payload_addr;

   ffa_pkg::addr_type link_m [ffa_pkg::PoolUnits];
   ffa_pkg::addr_type size_m [ffa_pkg::PoolUnits];
   ffa_pkg::addr_type head_m;
   bit                empty_m;
   outcome_type       pending_q[$];
   int                live_q[$];
   int                errors = 0;
   int                quiet = 0;
   bit                accepted_now = 0;

   first_fit_free_list_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_request_units(req_request_units),
      .req_block_addr(req_block_addr), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_payload_addr(rsp_payload_addr)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Allocate with first fit; cut a tail unless at most one unit would remain.
   function automatic outcome_type allocate_units(ffa_pkg::addr_type units);
      int unsigned steps, k;
      ffa_pkg::addr_type n, s, rest;
      ffa_pkg::addr_type cur, prev, nxt, q, tail;
      bit has_prev;
      outcome_type r;
      r = '{status: 1'b1, payload: '0};
      n = (units == '0) ? ffa_pkg::addr_type'(1) : units;
      if (empty_m) return r;
      cur = head_m;
      prev = '0;
      has_prev = 0;
      steps = 0;
      forever begin
         s = size_m[cur];
         if (s >= n) begin
            if (s - n <= 1) begin
               nxt = link_m[cur];
               if (nxt == cur) begin
                  empty_m = 1;
               end else if (has_prev) begin
                  link_m[prev] = nxt;
               end else begin
                  q = head_m;
                  k = 0;
                  while (link_m[q] != cur && k < ffa_pkg::PoolUnits) begin
                     q = link_m[q];
                     k++;
                  end
                  if (link_m[q] == cur) link_m[q] = nxt;
                  head_m = nxt;
               end
               r.payload = cur + ffa_pkg::addr_type'(1);
            end else begin
               rest = s - n - ffa_pkg::addr_type'(1);
               tail = cur + ffa_pkg::addr_type'(1) + rest;
               size_m[cur] = rest;
               size_m[tail] = n;
               r.payload = tail + ffa_pkg::addr_type'(1);
            end
            r.status = 1'b0;
            return r;
         end
         prev = cur;
         has_prev = 1;
         cur = link_m[cur];
         steps++;
         if (cur == head_m || steps >= ffa_pkg::PoolUnits) return r;
      end
   endfunction

   // Insert in address order and merge with free neighbors.
   function automatic void free_block(ffa_pkg::addr_type a);
      ffa_pkg::addr_type bp, p, nxt;
      int unsigned k;
      bp = a - ffa_pkg::addr_type'(1);
      if (empty_m) begin
         link_m[bp] = bp;
         head_m = bp;
         empty_m = 0;
         return;
      end
      p = head_m;
      k = 0;
      while (!(bp > p && bp < link_m[p]) && k < ffa_pkg::PoolUnits) begin
         nxt = link_m[p];
         if (p >= nxt && (bp > p || bp < nxt)) break;
         p = nxt;
         k++;
      end
      nxt = link_m[p];
      if (ffa_pkg::addr_type'(bp + 1 + size_m[bp]) == nxt) begin
         size_m[bp] = (bp == nxt) ? size_m[bp]
                                  : ffa_pkg::addr_type'(size_m[bp] + 1 + size_m[nxt]);
         if (nxt == p) begin
            link_m[bp] = bp;
            head_m = bp;
            return;
         end
         link_m[bp] = link_m[nxt];
      end else begin
         link_m[bp] = nxt;
      end
      if (ffa_pkg::addr_type'(p + 1 + size_m[p]) == bp) begin
         size_m[p] = ffa_pkg::addr_type'(size_m[p] + 1 + size_m[bp]);
         link_m[p] = link_m[bp];
         head_m = p;
      end else begin
         link_m[p] = bp;
         head_m = bp;
      end
   endfunction

   // Offer the item until it is taken, idling at random when may_idle is set, then queue its outcome.
   task automatic send(row_type row, bit may_idle);
      outcome_type r;
      bit taken;
      req_type <= row.kind;
      req_request_units <= row.units;
      req_block_addr <= row.addr;
      forever begin
         start <= (may_idle && $urandom_range(0, 99) < 23) ? 1'b0 : 1'b1;
         @(negedge clock);
         taken = start && !busy;
         @(posedge clock);
         if (taken) break;
      end
      accepted_now = 1;
      if (row.kind == ffa_pkg::REQ_ALLOC) begin
         r = allocate_units(row.units);
         if (!r.status) live_q.push_back(r.payload);
      end else begin
         free_block(row.addr);
         r = '{status: 1'b0, payload: '0};
         foreach (live_q[i]) begin
            if (live_q[i] == row.addr) begin
               live_q.delete(i);
               break;
            end
         end
      end
      if (row.typed) r = '{status: row.status, payload: row.payload};
      pending_q.push_back(r);
   endtask

   always @(negedge clock) begin
      outcome_type want;
      if (rsp_valid) begin
         if (pending_q.size() == 0) begin
            report("unexpected result", rsp_payload_addr, -1);
         end else begin
            want = pending_q.pop_front();
            if (rsp_status !== want.status) report("status", rsp_status, want.status);
            if (rsp_payload_addr !== want.payload)
               report("payload_addr", rsp_payload_addr, want.payload);
         end
      end
      if (rsp_valid || accepted_now || reset) quiet = 0;
      else quiet++;
      accepted_now = 0;
      if (quiet >= QuietLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      row_type directed[$];
      row_type row;
      int pick;
      link_m[0] = '0;
      size_m[0] = ffa_pkg::addr_type'(ffa_pkg::PoolUnits - 1);
      head_m = '0;
      empty_m = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed = '{
         '{ffa_pkg::REQ_ALLOC, 10'd1,    10'd512,  1, 1'b0, 10'd1023},
         '{ffa_pkg::REQ_ALLOC, 10'd1023, 10'd0,    1, 1'b1, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd0,    10'd1023, 1, 1'b0, 10'd1021},
         '{ffa_pkg::REQ_ALLOC, 10'd1019, 10'd341,  1, 1'b0, 10'd1},
         '{ffa_pkg::REQ_ALLOC, 10'd5,    10'd682,  1, 1'b1, 10'd0},
         '{ffa_pkg::REQ_FREE,  10'd1023, 10'd1,    1, 1'b0, 10'd0},
         '{ffa_pkg::REQ_FREE,  10'd0,    10'd1023, 1, 1'b0, 10'd0},
         '{ffa_pkg::REQ_FREE,  10'd512,  10'd1021, 1, 1'b0, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd1023, 10'd0,    0, 1'b0, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd1022, 10'd0,    0, 1'b0, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd512,  10'd0,    0, 1'b0, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd2,    10'd0,    0, 1'b0, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd3,    10'd0,    0, 1'b0, 10'd0},
         '{ffa_pkg::REQ_ALLOC, 10'd0,    10'd0,    0, 1'b0, 10'd0}
      };
      foreach (directed[i]) send(directed[i], 1'b1);
      for (int i = 0; i < RandomItems; i++) begin
         row.typed = 0;
         row.status = 1'b0;
         row.payload = '0;
         if (live_q.size() > 0 && ($urandom_range(0, 99) < 45 || live_q.size() > 40)) begin
            pick = $urandom_range(0, live_q.size() - 1);
            row.kind = ffa_pkg::REQ_FREE;
            row.units = ffa_pkg::addr_type'($urandom());
            row.addr = ffa_pkg::addr_type'(live_q[pick]);
         end else begin
            row.kind = ffa_pkg::REQ_ALLOC;
            row.addr = ffa_pkg::addr_type'($urandom());
            case ($urandom_range(0, 9))
               0:       row.units = ffa_pkg::addr_type'($urandom());
               1:       row.units = ffa_pkg::addr_type'($urandom_range(0, 255));
               default: row.units = ffa_pkg::addr_type'($urandom_range(0, 24));
            endcase
         end
         send(row, (i < 250 || i > 450));
      end
      start <= 1'b0;
      forever begin
         @(negedge clock);
         if (pending_q.size() == 0) break;
      end
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/ffa_pkg.sv
rtl/core/ffa_ram.sv
rtl/core/first_fit_free_list_allocator.sv
dv/tb_first_fit_free_list_allocator.sv
